// File: design/vbdma_pkg.sv
`default_nettype none

package vbdma_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int OFFSET_W    = 12;
    localparam int OPEN_W      = $clog2(BLOCK_BYTES + 1);
    localparam int ADDR_W      = 16;

    // request types
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_BLANK = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // register selects
    localparam logic [2:0] SEL_SRC_HI = 3'd0;
    localparam logic [2:0] SEL_SRC_LO = 3'd1;
    localparam logic [2:0] SEL_DST_HI = 3'd2;
    localparam logic [2:0] SEL_DST_LO = 3'd3;
    localparam logic [2:0] SEL_START  = 3'd4;

    localparam logic [7:0] STATUS_IDLE = 8'hFF;
    localparam int         MODE_BIT    = 7;

    typedef struct packed {
        logic [1:0] req_type;
        logic [2:0] reg_select;
        logic [7:0] write_data;
    } t_item;

    typedef struct packed {
        logic              copy_valid;
        logic [ADDR_W-1:0] copy_source;
        logic [ADDR_W-1:0] copy_target;
        logic [7:0]        status_byte;
        logic              busy_res;
    } t_result;

    // remaining blocks (partial block counts) minus one
    function automatic logic [7:0] blocks_status(input logic [OFFSET_W-1:0] bytes);
        logic [OFFSET_W-BLOCK_SHIFT:0] blocks;
        blocks = {1'b0, bytes[OFFSET_W-1:BLOCK_SHIFT]}
               + (OFFSET_W-BLOCK_SHIFT+1)'(|bytes[BLOCK_SHIFT-1:0]);
        blocks_status = 8'(blocks - (OFFSET_W-BLOCK_SHIFT+1)'(1));
    endfunction

endpackage

`default_nettype wire

// File: design/vbdma_addr.sv
`default_nettype none

module vbdma_addr
    import vbdma_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire t_item             i_item,
    output logic      [ADDR_W-1:0] o_source_base,
    output logic      [ADDR_W-1:0] o_target_base
);

    // only the bits that the masks let through are kept
    logic [7:0] r_src_hi, n_src_hi;
    logic [3:0] r_src_lo, n_src_lo;
    logic [4:0] r_dst_hi, n_dst_hi;
    logic [3:0] r_dst_lo, n_dst_lo;

    always_comb begin
        n_src_hi = r_src_hi;
        n_src_lo = r_src_lo;
        n_dst_hi = r_dst_hi;
        n_dst_lo = r_dst_lo;
        if (i_step && i_item.req_type == REQ_WRITE) begin
            unique case (i_item.reg_select)
                SEL_SRC_HI: n_src_hi = i_item.write_data;
                SEL_SRC_LO: n_src_lo = i_item.write_data[7:4];
                SEL_DST_HI: n_dst_hi = i_item.write_data[4:0];
                SEL_DST_LO: n_dst_lo = i_item.write_data[7:4];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_hi <= '0;
            r_src_lo <= '0;
            r_dst_hi <= '0;
            r_dst_lo <= '0;
        end else begin
            r_src_hi <= n_src_hi;
            r_src_lo <= n_src_lo;
            r_dst_hi <= n_dst_hi;
            r_dst_lo <= n_dst_lo;
        end
    end

    assign o_source_base = {r_src_hi, r_src_lo, 4'b0000};
    assign o_target_base = {3'b100, r_dst_hi, r_dst_lo, 4'b0000};

endmodule

`default_nettype wire

// File: design/vbdma_xfer.sv
`default_nettype none

module vbdma_xfer
    import vbdma_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire t_item             i_item,
    input  wire logic [ADDR_W-1:0] i_source_base,
    input  wire logic [ADDR_W-1:0] i_target_base,
    output t_result                o_result
);

    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic [OFFSET_W-1:0] r_bytes_left, n_bytes_left;
    logic [OPEN_W-1:0]   r_open, n_open;
    logic                r_blank_mode, n_blank_mode;
    logic                r_active, n_active;
    logic [7:0]          r_status, n_status;

    logic [7:0]          start_blocks;
    logic [OFFSET_W-1:0] start_bytes;
    logic [OFFSET_W-1:0] left_dec;
    logic                can_copy;

    assign start_blocks = {1'b0, i_item.write_data[6:0]} + 8'd1;
    assign start_bytes  = OFFSET_W'({start_blocks, {BLOCK_SHIFT{1'b0}}});
    assign left_dec     = r_bytes_left - OFFSET_W'(1);
    assign can_copy     = r_active && (r_bytes_left != '0)
                          && (!r_blank_mode || (r_open != '0));

    always_comb begin
        n_offset     = r_offset;
        n_bytes_left = r_bytes_left;
        n_open       = r_open;
        n_blank_mode = r_blank_mode;
        n_active     = r_active;
        n_status     = r_status;
        o_result     = '0;
        if (i_step) begin
            unique case (i_item.req_type)
                REQ_WRITE: begin
                    if (i_item.reg_select == SEL_START) begin
                        n_bytes_left = start_bytes;
                        n_offset     = '0;
                        n_open       = '0;
                        n_blank_mode = i_item.write_data[MODE_BIT];
                        n_active     = (start_bytes != '0);
                        n_status     = (start_bytes != '0) ? blocks_status(start_bytes)
                                                           : STATUS_IDLE;
                    end
                end
                REQ_BLANK: begin
                    // releases do not stack
                    if (r_active && r_blank_mode && r_open == '0) begin
                        n_open = OPEN_W'(BLOCK_BYTES);
                    end
                end
                REQ_TICK: begin
                    if (can_copy) begin
                        o_result.copy_valid  = 1'b1;
                        o_result.copy_source = i_source_base + ADDR_W'(r_offset);
                        o_result.copy_target = i_target_base + ADDR_W'(r_offset);
                        n_offset     = r_offset + OFFSET_W'(1);
                        n_bytes_left = left_dec;
                        if (r_blank_mode) begin
                            n_open = r_open - OPEN_W'(1);
                        end
                        if (left_dec == '0) begin
                            n_active = 1'b0;
                            n_open   = '0;
                            n_status = STATUS_IDLE;
                        end else begin
                            n_status = blocks_status(left_dec);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        o_result.status_byte = n_status;
        o_result.busy_res    = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset     <= '0;
            r_bytes_left <= '0;
            r_open       <= '0;
            r_blank_mode <= 1'b0;
            r_active     <= 1'b0;
            r_status     <= STATUS_IDLE;
        end else begin
            r_offset     <= n_offset;
            r_bytes_left <= n_bytes_left;
            r_open       <= n_open;
            r_blank_mode <= n_blank_mode;
            r_active     <= n_active;
            r_status     <= n_status;
        end
    end

    a_active_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_bytes_left != '0)
        else $error("active transfer with no bytes left");

    a_idle_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> r_status == STATUS_IDLE)
        else $error("idle status is not 0xff");

    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_open <= OPEN_W'(BLOCK_BYTES)) && (r_blank_mode || r_open == '0))
        else $error("released byte count out of range");

    a_copy_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.copy_valid)
        |=> r_bytes_left == $past(left_dec) && r_offset == $past(r_offset) + OFFSET_W'(1))
        else $error("copy did not advance the counters");

endmodule

`default_nettype wire

// File: design/vram_block_dma_controller_core.sv
// channel | valid       | ready       | payload
// in      | i_in_valid  | o_in_ready  | i_req_type, i_reg_select, i_write_data
// out     | o_out_valid | i_out_ready | o_copy_valid, o_copy_source, o_copy_target,
//         |             |             | o_status_byte, o_busy_res
//
// one item per cycle while the output is not stalled; each item gives one result
// the item is processed as it leaves the input register, where the state updates
// reset leaves both stages empty, source 0, destination 0x8000, status 0xff
// a stalled result holds the output register and the input register behind it;
// ready returns as soon as the result is taken
`default_nettype none

module vram_block_dma_controller_core
    import vbdma_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_req_type,
    input  wire logic [2:0]        i_reg_select,
    input  wire logic [7:0]        i_write_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_copy_valid,
    output logic      [ADDR_W-1:0] o_copy_source,
    output logic      [ADDR_W-1:0] o_copy_target,
    output logic      [7:0]        o_status_byte,
    output logic                   o_busy_res
);

    logic              r_in_valid;
    t_item             r_in_item;
    logic              r_out_valid;
    t_result           r_result;
    t_result           result;
    logic              out_free;
    logic              step;
    logic [ADDR_W-1:0] source_base;
    logic [ADDR_W-1:0] target_base;

    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= '{req_type: i_req_type, reg_select: i_reg_select,
                           write_data: i_write_data};
        end
    end

    vbdma_addr u_addr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_item        (r_in_item),
        .o_source_base (source_base),
        .o_target_base (target_base)
    );

    vbdma_xfer u_xfer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_item        (r_in_item),
        .i_source_base (source_base),
        .i_target_base (target_base),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_result <= result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_copy_valid  = r_result.copy_valid;
    assign o_copy_source = r_result.copy_source;
    assign o_copy_target = r_result.copy_target;
    assign o_status_byte = r_result.status_byte;
    assign o_busy_res    = r_result.busy_res;

endmodule

`default_nettype wire
